### hw/rtl/sadm_pkg.sv
// shared types and constants for the signed integer alu with divider
// no dependencies; imported by the core, the adder, the checker and the bench

package sadm_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam func_t FUNC_ADD = 3'd0;
  localparam func_t FUNC_SUB = 3'd1;
  localparam func_t FUNC_MUL = 3'd2;
  localparam func_t FUNC_DIV = 3'd3;
  localparam func_t FUNC_MOD = 3'd4;

  // operand steering for the shared adder
  typedef struct packed {
    logic sub;
  } add_ctl_t;

endpackage

### hw/rtl/sadm_addsub.sv
// shared add/subtract unit used by every step of the alu sequencer
// depends on sadm_pkg for the control struct

module sadm_addsub #(
  parameter int N = 34
) (
  input  logic [N-1:0]     a,
  input  logic [N-1:0]     b,
  input  sadm_pkg::add_ctl_t ctl,
  output logic [N-1:0]     sum
);
  import sadm_pkg::*;

  logic [N-1:0] b_inv;

  assign b_inv = ctl.sub ? ~b : b;
  assign sum   = a + b_inv + N'(ctl.sub);

endmodule

### hw/rtl/signed_int_alu_div_mod_core.sv
// signed integer alu: add, subtract, multiply, divide, modulo with sticky error
// depends on sadm_pkg and sadm_addsub
//
// usage: drive func, x and y and raise start while busy is low; that edge takes
// the beat. busy stays high while the item is worked on, and a single-cycle done
// strobe marks result and error_code. the receiver cannot stall; the result
// register holds until the next done. a new start may be given in the cycle
// that done is high.
// steps from the accepted beat to the done strobe:
//   add, subtract, unused codes, zero divisor: the S_ALU step
//   multiply: one shift-add step (S_MUL) per multiplier bit
//   divide, modulo: two magnitude steps (S_NEGX, S_NEGY), one restoring step
//   (S_DIV) per dividend bit, one sign fixup (S_FIX)
// all of it goes through one shared adder of WIDTH + 2 bits.
// operands use their low WIDTH bits sign-extended; results are sign-extended or
// truncated to 32 bits. reset returns to idle and clears the error register.

module signed_int_alu_div_mod_core #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sadm_pkg::func_t      func,
  input  sadm_pkg::data_t      x,
  input  sadm_pkg::data_t      y,
  output logic                 done,
  output sadm_pkg::data_t      result,
  output logic                 error_code
);
  import sadm_pkg::*;

  localparam int UW    = WIDTH + 2;
  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ALU, S_NEGX, S_NEGY, S_MUL, S_DIV, S_FIX
  } state_t;

  state_t             state;
  func_t              func_r;
  logic [WIDTH-1:0]   a;
  logic [WIDTH-1:0]   b;
  logic [WIDTH-1:0]   acc;
  logic [CNT_W-1:0]   cnt;
  logic               xneg;
  logic               yneg;
  logic               last_error;

  logic [WIDTH-1:0]   x_ext;
  logic [WIDTH-1:0]   y_ext;
  logic [UW-1:0]      op_a;
  logic [UW-1:0]      op_b;
  add_ctl_t           ctl;
  logic [UW-1:0]      sum;
  logic [WIDTH-1:0]   sum_w;
  logic [WIDTH:0]     shifted;
  logic               last_step;

  assign x_ext     = WIDTH'($signed(x));
  assign y_ext     = WIDTH'($signed(y));
  assign sum_w     = sum[WIDTH-1:0];
  assign shifted   = {acc, a[WIDTH-1]};
  assign last_step = (cnt == CNT_W'(WIDTH - 1));

  assign busy       = (state != S_IDLE);
  assign error_code = last_error;

  // operand steering for the shared adder
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    ctl.sub = 1'b0;
    case (state)
      S_ALU: begin
        op_a    = {2'b00, a};
        op_b    = {2'b00, b};
        ctl.sub = (func_r == FUNC_SUB);
      end
      S_NEGX: begin
        op_b    = {2'b00, a};
        ctl.sub = 1'b1;
      end
      S_NEGY: begin
        op_b    = {2'b00, b};
        ctl.sub = 1'b1;
      end
      S_MUL: begin
        op_a = {2'b00, acc};
        op_b = {2'b00, a};
      end
      S_DIV: begin
        op_a    = {1'b0, shifted};
        op_b    = {2'b00, b};
        ctl.sub = 1'b1;
      end
      S_FIX: begin
        // quotient negate, or |y| - remainder for modulo
        if (func_r == FUNC_MOD) begin
          op_a = {2'b00, b};
          op_b = {2'b00, acc};
        end else begin
          op_b = {2'b00, a};
        end
        ctl.sub = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  sadm_addsub #(.N(UW)) u_addsub (
    .a   (op_a),
    .b   (op_b),
    .ctl (ctl),
    .sum (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      last_error <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            func_r <= func;
            a      <= x_ext;
            b      <= y_ext;
            acc    <= '0;
            cnt    <= '0;
            xneg   <= x_ext[WIDTH-1];
            yneg   <= y_ext[WIDTH-1];
            if (func == FUNC_MUL) begin
              state <= S_MUL;
            end else if ((func == FUNC_DIV || func == FUNC_MOD) && y_ext != '0) begin
              state <= S_NEGX;
            end else begin
              state <= S_ALU;
            end
          end
        end
        S_ALU: begin
          state <= S_IDLE;
          done  <= 1'b1;
          case (func_r)
            FUNC_ADD, FUNC_SUB: begin
              result <= DATA_W'($signed(sum_w));
            end
            FUNC_DIV, FUNC_MOD: begin
              // only reached here with a zero divisor
              result     <= '1;
              last_error <= 1'b1;
            end
            default: begin
              result <= '0;
            end
          endcase
        end
        S_NEGX: begin
          if (xneg) begin
            a <= sum_w;
          end
          state <= S_NEGY;
        end
        S_NEGY: begin
          if (yneg) begin
            b <= sum_w;
          end
          state <= S_DIV;
        end
        S_MUL: begin
          if (b[0]) begin
            acc <= sum_w;
          end
          a   <= {a[WIDTH-2:0], 1'b0};
          b   <= {1'b0, b[WIDTH-1:1]};
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= DATA_W'($signed(b[0] ? sum_w : acc));
          end
        end
        S_DIV: begin
          // restoring step: keep the difference when no borrow
          if (!sum[UW-1]) begin
            acc <= sum_w;
          end else begin
            acc <= shifted[WIDTH-1:0];
          end
          a   <= {a[WIDTH-2:0], ~sum[UW-1]};
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state      <= S_IDLE;
          done       <= 1'b1;
          last_error <= 1'b0;
          if (func_r == FUNC_MOD) begin
            result <= DATA_W'($signed((xneg && acc != '0) ? sum_w : acc));
          end else begin
            result <= DATA_W'($signed((xneg ^ yneg) ? sum_w : a));
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/sadm_check.sv
// port-level checks for the signed integer alu with divider
// depends on sadm_pkg; bound to signed_int_alu_div_mod_core below

module sadm_check (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input sadm_pkg::data_t result,
  input logic            error_code
);
  import sadm_pkg::*;

  // a result only shows once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // an accepted beat makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // finishing an item always delivers its result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (done || $past(rst)))
    else $error("busy dropped without a result");

  // the error flag moves only with a result
  a_err_stable: assert property (@(posedge clk) disable iff (rst)
    (!done && !$past(rst)) |-> $stable(error_code))
    else $error("error flag changed without a result");

  // a zero-divisor result is all ones
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    (done && error_code && !$past(error_code) && !$past(rst)) |-> (result == '1))
    else $error("new error without all-ones result");

endmodule

bind signed_int_alu_div_mod_core sadm_check u_sadm_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .result     (result),
  .error_code (error_code)
);

### test/testbench.sv
// self-checking bench for signed_int_alu_div_mod_core: directed corner ops, then random ops
// depends on sadm_pkg and the core rtl; the scoreboard predicts each beat and checks done beats

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sadm_pkg::*;

  localparam func_t FUNC_UNUSED_LO = 3'd5;
  localparam func_t FUNC_UNUSED_HI = 3'd7;
  localparam data_t MIN_VAL = 32'h8000_0000;
  localparam data_t MAX_VAL = 32'h7fff_ffff;
  localparam data_t ALL_ONES = 32'hffff_ffff;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    data_t value;
    logic err;
  } alu_out_t;

  class alu_scoreboard;
    alu_out_t pending_results[$];
    logic div_err;
    int mismatches;

    function new();
      div_err = 1'b0;
      mismatches = 0;
    endfunction

    // predicts the result of one accepted beat
    function void note_operation(func_t f, data_t a, data_t b);
      data_t r;
      data_t mag_a;
      data_t mag_b;
      alu_out_t o;
      mag_a = a[DATA_W-1] ? -a : a;
      mag_b = b[DATA_W-1] ? -b : b;
      case (f)
        FUNC_ADD: r = a + b;
        FUNC_SUB: r = a - b;
        FUNC_MUL: r = a * b;
        FUNC_DIV, FUNC_MOD: begin
          if (b == '0) begin
            div_err = 1'b1;
            r = ALL_ONES;
          end else begin
            div_err = 1'b0;
            if (f == FUNC_DIV) begin
              r = mag_a / mag_b;
              if (a[DATA_W-1] != b[DATA_W-1]) r = -r;
            end else begin
              // remainder folded into [0, |y|)
              r = mag_a % mag_b;
              if (a[DATA_W-1] && r != '0) r = mag_b - r;
            end
          end
        end
        default: r = '0;
      endcase
      o.value = r;
      o.err = div_err;
      pending_results.push_back(o);
    endfunction

    function void report(string what, data_t exp_v, data_t act_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %0s: expected %h, got %h", what, exp_v, act_v);
    endfunction

    function void check_result(data_t r, logic e);
      alu_out_t o;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, r);
      end else begin
        o = pending_results.pop_front();
        if (r !== o.value) report("result", o.value, r);
        if (e !== o.err) report("error_code", data_t'(o.err), data_t'(e));
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  func_t func;
  data_t x;
  data_t y;
  logic done;
  data_t result;
  logic error_code;

  alu_scoreboard sb;

  signed_int_alu_div_mod_core uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .x(x),
    .y(y),
    .done(done),
    .result(result),
    .error_code(error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result, error_code);
  end

  // one command beat; optional random idle cycles ahead of it
  task automatic send_op(func_t f, data_t a, data_t b, bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    x <= a;
    y <= b;
    do @(posedge clk); while (busy);
    sb.note_operation(f, a, b);
  endtask

  function automatic data_t pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return '0;
      3: return ALL_ONES;
      4: return data_t'($urandom_range(0, 31)) - data_t'(16);
      5: return data_t'(1);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic func_t pick_func();
    int n;
    n = $urandom_range(0, 15);
    if (n < 14) return func_t'(n % 5);
    return func_t'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
  endfunction

  initial begin
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_ADD;
    x <= '0;
    y <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrap on add, subtract and multiply
    send_op(FUNC_ADD, MAX_VAL, data_t'(1), 1'b1);
    send_op(FUNC_ADD, MIN_VAL, MIN_VAL, 1'b1);
    send_op(FUNC_SUB, MIN_VAL, data_t'(1), 1'b1);
    send_op(FUNC_SUB, '0, MIN_VAL, 1'b1);
    send_op(FUNC_MUL, MIN_VAL, ALL_ONES, 1'b1);
    send_op(FUNC_MUL, MAX_VAL, MAX_VAL, 1'b0);
    // truncating divide, all sign combinations
    send_op(FUNC_DIV, data_t'(7), data_t'(2), 1'b0);
    send_op(FUNC_DIV, -data_t'(7), data_t'(2), 1'b0);
    send_op(FUNC_DIV, data_t'(7), -data_t'(2), 1'b1);
    send_op(FUNC_DIV, -data_t'(7), -data_t'(2), 1'b1);
    // quotient overflow and most negative operands
    send_op(FUNC_DIV, MIN_VAL, ALL_ONES, 1'b1);
    send_op(FUNC_DIV, MIN_VAL, MIN_VAL, 1'b1);
    // zero divisor sets the sticky flag, add and unused codes keep it
    send_op(FUNC_DIV, MAX_VAL, '0, 1'b0);
    send_op(FUNC_ADD, data_t'(3), data_t'(4), 1'b0);
    send_op(FUNC_UNUSED_LO, MAX_VAL, MIN_VAL, 1'b1);
    send_op(FUNC_MOD, -data_t'(7), data_t'(3), 1'b1);
    send_op(FUNC_MOD, data_t'(7), -data_t'(3), 1'b1);
    send_op(FUNC_MOD, MIN_VAL, ALL_ONES, 1'b0);
    send_op(FUNC_MOD, MIN_VAL, data_t'(3), 1'b1);
    send_op(FUNC_MOD, MIN_VAL, MIN_VAL, 1'b1);
    send_op(FUNC_MOD, -data_t'(9), MAX_VAL, 1'b1);
    send_op(FUNC_MOD, data_t'(5), '0, 1'b1);
    send_op(FUNC_UNUSED_LO + 3'd1, ALL_ONES, ALL_ONES, 1'b0);
    send_op(FUNC_UNUSED_HI, ALL_ONES, ALL_ONES, 1'b1);
    send_op(FUNC_SUB, ALL_ONES, ALL_ONES, 1'b1);

    // random beats, with stretches of back-to-back starts
    for (int i = 0; i < 950; i++)
      send_op(pick_func(), pick_operand(), pick_operand(), ((i / 60) % 3) != 1);

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sadm_pkg.sv
hw/rtl/sadm_addsub.sv
hw/rtl/signed_int_alu_div_mod_core.sv
hw/rtl/sadm_check.sv
test/testbench.sv
